// File: sv/tensor_axis_reverse_addresser_core_assert.svh
// Assertion macros used by the top level of the tensor axis reverse addresser.
`ifndef TENSOR_AXIS_REVERSE_ADDRESSER_CORE_ASSERT_SVH
`define TENSOR_AXIS_REVERSE_ADDRESSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TARA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TARA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tara_pkg.sv
// Package with shared constants, register codes and types of the reverse addresser.
package tara_pkg;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_MAX_DIMS  = 4;
    localparam int DEFAULT_DIM_BITS  = 16;
    localparam int DEFAULT_ADDR_BITS = 32;

    // Fixed field and register widths.
    localparam int VALUE_BITS     = 32;
    localparam int OUT_ADDR_BITS  = 32;
    localparam int SIZE_REGS      = 4;
    localparam int SIZE_IDX_BITS  = 2;
    localparam int SIZE_BITS      = 16;
    localparam int MASK_BITS      = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_SIZE_0   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_SIZE_1   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_SIZE_2   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_SIZE_3   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_MASK = 3'd4;

    // Flow control that travels with a word from cell to cell.
    typedef struct packed {
        logic valid;
        logic last;
    } tara_flow_t;

endpackage

// File: sv/tensor_axis_reverse_addresser_core.sv
// An accepted word passes through the stage register of each dimension cell, innermost first.
// Throughput: one word per cycle while m_ready stays high; each dimension cell adds one weighted index per cycle.
// The index counters step with carry in the cycle a word is accepted, so back-to-back
// words see the right position. Reset (aresetn low, synchronous) clears the counters
// and the pipeline, sets all sizes to 1 and the reverse mask to 0.
// Top level of the tensor axis reverse addresser.
`include "tensor_axis_reverse_addresser_core_assert.svh"

module tensor_axis_reverse_addresser_core #(
    parameter int MAX_DIMS  = tara_pkg::DEFAULT_MAX_DIMS,
    parameter int DIM_BITS  = tara_pkg::DEFAULT_DIM_BITS,
    parameter int ADDR_BITS = tara_pkg::DEFAULT_ADDR_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [tara_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tara_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tara_pkg::VALUE_BITS-1:0]       s_element_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tara_pkg::VALUE_BITS-1:0]       m_out_value,
    output logic [tara_pkg::OUT_ADDR_BITS-1:0]    m_dest_address,
    output logic                                  m_last_element
);

    logic [tara_pkg::SIZE_BITS-1:0]    dim_size_reg [tara_pkg::SIZE_REGS];
    logic [tara_pkg::MASK_BITS-1:0]    reverse_mask_reg;

    logic [DIM_BITS-1:0]               eff_size [MAX_DIMS];
    logic                              eff_rev  [MAX_DIMS];
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] idx_vec;
    logic                              accept;

    tara_pkg::tara_flow_t              flow_chain   [MAX_DIMS+1];
    logic [tara_pkg::VALUE_BITS-1:0]   value_chain  [MAX_DIMS+1];
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] idx_chain    [MAX_DIMS+1];
    logic [ADDR_BITS-1:0]              addr_chain   [MAX_DIMS+1];
    logic [ADDR_BITS-1:0]              stride_chain [MAX_DIMS+1];
    logic                              ready_chain  [MAX_DIMS+1];
    logic                              carry_chain  [MAX_DIMS+1];

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tara_pkg::SIZE_REGS; i++) begin
                dim_size_reg[i] <= tara_pkg::SIZE_BITS'(1);
            end
            reverse_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index) inside
                tara_pkg::REG_DIM_SIZE_0, tara_pkg::REG_DIM_SIZE_1,
                tara_pkg::REG_DIM_SIZE_2, tara_pkg::REG_DIM_SIZE_3: begin
                    dim_size_reg[cfg_index[tara_pkg::SIZE_IDX_BITS-1:0]] <= cfg_wdata;
                end
                tara_pkg::REG_REVERSE_MASK: begin
                    reverse_mask_reg <= cfg_wdata[tara_pkg::MASK_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    // Input word enters at the innermost cell with address 0 and stride 1.
    assign flow_chain[MAX_DIMS].valid = s_valid;
    assign flow_chain[MAX_DIMS].last  = carry_chain[0];
    assign value_chain[MAX_DIMS]      = s_element_value;
    assign idx_chain[MAX_DIMS]        = idx_vec;
    assign addr_chain[MAX_DIMS]       = '0;
    assign stride_chain[MAX_DIMS]     = ADDR_BITS'(1);
    assign carry_chain[MAX_DIMS]      = 1'b1;
    assign s_ready                    = ready_chain[MAX_DIMS];
    assign ready_chain[0]             = m_ready;

    // One cell per dimension; words and carries move from inner to outer dimensions.
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
        logic [DIM_BITS-1:0] size_raw;

        if (d < tara_pkg::SIZE_REGS) begin : g_reg
            assign size_raw   = DIM_BITS'(dim_size_reg[d]);
            assign eff_rev[d] = reverse_mask_reg[d];
        end else begin : g_fixed
            assign size_raw   = DIM_BITS'(1);
            assign eff_rev[d] = 1'b0;
        end

        // A size of zero behaves as size one.
        assign eff_size[d] = (size_raw == '0) ? DIM_BITS'(1) : size_raw;

        tara_dim_cell #(
            .MAX_DIMS  (MAX_DIMS),
            .DIM_BITS  (DIM_BITS),
            .ADDR_BITS (ADDR_BITS),
            .DIM       (d)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .dim_size  (eff_size[d]),
            .dim_rev   (eff_rev[d]),
            .step      (accept),
            .carry_in  (carry_chain[d+1]),
            .carry_out (carry_chain[d]),
            .idx_out   (idx_vec[d]),
            .up_flow   (flow_chain[d+1]),
            .up_value  (value_chain[d+1]),
            .up_idx    (idx_chain[d+1]),
            .up_addr   (addr_chain[d+1]),
            .up_stride (stride_chain[d+1]),
            .up_ready  (ready_chain[d+1]),
            .dn_flow   (flow_chain[d]),
            .dn_value  (value_chain[d]),
            .dn_idx    (idx_chain[d]),
            .dn_addr   (addr_chain[d]),
            .dn_stride (stride_chain[d]),
            .dn_ready  (ready_chain[d])
        );
    end

    // The outermost cell's stage register is the output register.
    assign m_valid        = flow_chain[0].valid;
    assign m_last_element = flow_chain[0].last;
    assign m_out_value    = value_chain[0];
    assign m_dest_address = tara_pkg::OUT_ADDR_BITS'(addr_chain[0]);

    // The last word of a tensor leaves every counter at zero.
    `TARA_ASSERT_NEXT(a_last_wraps, aclk, aresetn, accept && carry_chain[0], idx_vec == '0, "counters did not wrap after the last word")

    // Counters move only when a word is accepted.
    `TARA_ASSERT_NEXT(a_idx_hold, aclk, aresetn, !accept, $stable(idx_vec), "counters changed without an accepted word")

    // An empty output stage means the whole chain can take a word.
    `TARA_ASSERT_SAME(a_ready_on_bubble, aclk, aresetn, !m_valid, s_ready, "input stalled although the output stage is empty")

endmodule

// File: sv/tara_dim_cell.sv
// One dimension cell: index counter with carry and one stage of the address pipeline.
module tara_dim_cell #(
    parameter int MAX_DIMS  = tara_pkg::DEFAULT_MAX_DIMS,
    parameter int DIM_BITS  = tara_pkg::DEFAULT_DIM_BITS,
    parameter int ADDR_BITS = tara_pkg::DEFAULT_ADDR_BITS,
    parameter int DIM       = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [DIM_BITS-1:0]                 dim_size,
    input  logic                                dim_rev,
    input  logic                                step,
    input  logic                                carry_in,
    output logic                                carry_out,
    output logic [DIM_BITS-1:0]                 idx_out,
    input  tara_pkg::tara_flow_t                up_flow,
    input  logic [tara_pkg::VALUE_BITS-1:0]     up_value,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]   up_idx,
    input  logic [ADDR_BITS-1:0]                up_addr,
    input  logic [ADDR_BITS-1:0]                up_stride,
    output logic                                up_ready,
    output tara_pkg::tara_flow_t                dn_flow,
    output logic [tara_pkg::VALUE_BITS-1:0]     dn_value,
    output logic [MAX_DIMS-1:0][DIM_BITS-1:0]   dn_idx,
    output logic [ADDR_BITS-1:0]                dn_addr,
    output logic [ADDR_BITS-1:0]                dn_stride,
    input  logic                                dn_ready
);

    logic [DIM_BITS-1:0]               idx_reg, idx_next;
    logic                              at_end;
    logic [ADDR_BITS-1:0]              dest_idx;
    logic [ADDR_BITS-1:0]              addr_next, stride_next;
    logic                              valid_reg, last_reg;
    logic [tara_pkg::VALUE_BITS-1:0]   value_reg;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] idx_vec_reg;
    logic [ADDR_BITS-1:0]              addr_reg, stride_reg;

    // The counter sits at its end when it reaches size-1 or has run past it.
    always_comb begin
        at_end    = (idx_reg >= (dim_size - DIM_BITS'(1)));
        carry_out = carry_in && at_end;
        idx_next  = idx_reg;
        if (step && carry_in) begin
            idx_next = at_end ? '0 : idx_reg + DIM_BITS'(1);
        end
    end

    assign idx_out = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    // Destination index of this dimension, weighted and added to the running address.
    always_comb begin
        dest_idx = ADDR_BITS'(up_idx[DIM]);
        if (dim_rev) begin
            dest_idx = ADDR_BITS'(dim_size) - ADDR_BITS'(1) - ADDR_BITS'(up_idx[DIM]);
        end
        addr_next   = up_addr + ADDR_BITS'(dest_idx * up_stride);
        stride_next = ADDR_BITS'(up_stride * ADDR_BITS'(dim_size));
    end

    // A stage takes a new word when it is empty or its word moves on.
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_flow.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_flow.valid) begin
            last_reg    <= up_flow.last;
            value_reg   <= up_value;
            idx_vec_reg <= up_idx;
            addr_reg    <= addr_next;
            stride_reg  <= stride_next;
        end
    end

    assign dn_flow.valid = valid_reg;
    assign dn_flow.last  = last_reg;
    assign dn_value      = value_reg;
    assign dn_idx        = idx_vec_reg;
    assign dn_addr       = addr_reg;
    assign dn_stride     = stride_reg;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench of the tensor axis reverse addresser: directed table, then random words.
module tb_top;

    localparam int NDIM           = tara_pkg::DEFAULT_MAX_DIMS;
    localparam int PIPE_DEPTH     = tara_pkg::DEFAULT_MAX_DIMS;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int CHUNK_WORDS    = 50;
    localparam int CHUNKS         = 5;

    // Indexes past the reverse mask that the block must ignore.
    localparam logic [tara_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO =
        tara_pkg::REG_REVERSE_MASK + 3'd1;
    localparam logic [tara_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = '1;

    typedef struct packed {
        logic [tara_pkg::VALUE_BITS-1:0]    value;
        logic [tara_pkg::OUT_ADDR_BITS-1:0] addr;
        logic                               last;
    } flip_word_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                           kind;
        logic [tara_pkg::CFG_INDEX_BITS-1:0] idx;
        logic [tara_pkg::CFG_DATA_BITS-1:0]  data;
        logic [tara_pkg::VALUE_BITS-1:0]     value;
        logic                                typed;
        logic [tara_pkg::OUT_ADDR_BITS-1:0]  addr;
        logic                                last;
    } plan_row_t;

    // Directed table. Rows with typed set carry their own expected address and last flag.
    localparam int PLAN_LEN = 35;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // All sizes are 1 after reset, so every word is a whole tensor at offset 0.
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{ROW_WORD, 3'd0, 16'h0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
        // Writes to unused indexes change nothing.
        '{ROW_CFG, REG_SPARE_LO, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, REG_SPARE_HI, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'hA5A5_A5A5, 1'b1, 32'h0000_0000, 1'b1},
        // A zero size acts as size 1, and reversing a size-1 axis is a no-op.
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_3, 16'h0000, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_REVERSE_MASK, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h5A5A_5A5A, 1'b1, 32'h0000_0000, 1'b1},
        // Largest innermost size, reversed.
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_3, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h1234_5678, 1'b1, 32'h0000_FFFE, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h8765_4321, 1'b1, 32'h0000_FFFD, 1'b0},
        // Shrinking the innermost size leaves its counter past the end.
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_0, 16'h0002, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_1, 16'h0000, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_2, 16'h0003, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_3, 16'h0002, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_REVERSE_MASK, 16'h0005, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0004, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0008, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0010, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0020, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0040, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0080, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0100, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0200, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0400, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'h0000_0800, 1'b0, 32'h0, 1'b0},
        // All sizes at their largest and all axes reversed: the address wraps.
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_0, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_1, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_2, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_DIM_SIZE_3, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, tara_pkg::REG_REVERSE_MASK, 16'h000F, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'hDEAD_BEEF, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 3'd0, 16'h0000, 32'hC0FF_EE00, 1'b0, 32'h0, 1'b0}
    };

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [tara_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [tara_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [tara_pkg::VALUE_BITS-1:0]     s_element_value = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [tara_pkg::VALUE_BITS-1:0]     m_out_value;
    logic [tara_pkg::OUT_ADDR_BITS-1:0]  m_dest_address;
    logic                                m_last_element;

    // Mirror of the block's registers and source position.
    logic [tara_pkg::SIZE_BITS-1:0] shape_size [NDIM];
    logic [tara_pkg::MASK_BITS-1:0] flip_mask;
    logic [tara_pkg::SIZE_BITS-1:0] src_pos [NDIM];

    flip_word_t pending_words [$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_left = 0;
    logic       hold_req = 1'b0;
    logic       hold_taken = 1'b0;
    int         quiet_cycles = 0;

    tensor_axis_reverse_addresser_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_value     (m_out_value),
        .m_dest_address  (m_dest_address),
        .m_last_element  (m_last_element)
    );

    always #6 aclk = ~aclk;

    // Destination offset of the current source position, then a carry step of the counters.
    function automatic flip_word_t flip_predict(input logic [tara_pkg::VALUE_BITS-1:0] value);
        logic [63:0] addr;
        logic [63:0] stride;
        logic [63:0] sz;
        logic [63:0] pos;
        logic [63:0] dst;
        logic        carry;
        flip_word_t  r;
        addr   = 64'd0;
        stride = 64'd1;
        for (int d = NDIM - 1; d >= 0; d--) begin
            sz     = (shape_size[d] == '0) ? 64'd1 : {48'd0, shape_size[d]};
            pos    = {48'd0, src_pos[d]};
            dst    = flip_mask[d] ? (sz - 64'd1 - pos) : pos;
            addr   = addr + dst * stride;
            stride = stride * sz;
        end
        carry = 1'b1;
        for (int d = NDIM - 1; d >= 0; d--) begin
            if (carry) begin
                sz  = (shape_size[d] == '0) ? 64'd1 : {48'd0, shape_size[d]};
                pos = {48'd0, src_pos[d]};
                if (pos >= sz - 64'd1) begin
                    src_pos[d] = '0;
                end else begin
                    src_pos[d] = src_pos[d] + 16'd1;
                    carry      = 1'b0;
                end
            end
        end
        r.value = value;
        r.addr  = addr[tara_pkg::OUT_ADDR_BITS-1:0];
        r.last  = carry;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch in %s: got %h, want %h at %0t", what, got, want, $time);
    endtask

    // One register write, mirrored into the predictor's copy.
    task automatic write_reg(input logic [tara_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [tara_pkg::CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= tara_pkg::REG_DIM_SIZE_3) begin
            shape_size[idx[tara_pkg::SIZE_IDX_BITS-1:0]] = data;
        end else if (idx == tara_pkg::REG_REVERSE_MASK) begin
            flip_mask = data[tara_pkg::MASK_BITS-1:0];
        end
        @(posedge aclk);
    endtask

    // Stop offering words and wait until every pending word has come back.
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    // Offer one word after a random gap; record its expectation when it is accepted.
    task automatic push_word(input logic [tara_pkg::VALUE_BITS-1:0] value, input logic typed,
                             input logic [tara_pkg::OUT_ADDR_BITS-1:0] addr, input logic last);
        flip_word_t r;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid         <= 1'b1;
        s_element_value <= value;
        do @(posedge aclk); while (!s_ready);
        r = flip_predict(value);
        if (typed) begin
            r.addr = addr;
            r.last = last;
        end
        pending_words.push_back(r);
    endtask

    // Random shape, mostly small so that tensors complete often, with extremes mixed in.
    task automatic pick_shape();
        logic [tara_pkg::CFG_DATA_BITS-1:0] v;
        for (int d = 0; d < tara_pkg::SIZE_REGS; d++) begin
            case ($urandom_range(0, 9))
                0: begin
                    v = '0;
                end
                1: begin
                    v = '1;
                end
                2: begin
                    v = tara_pkg::CFG_DATA_BITS'($urandom);
                end
                default: begin
                    v = tara_pkg::CFG_DATA_BITS'($urandom_range(1, 4));
                end
            endcase
            write_reg(tara_pkg::CFG_INDEX_BITS'(tara_pkg::REG_DIM_SIZE_0 + d), v);
        end
        write_reg(tara_pkg::REG_REVERSE_MASK, tara_pkg::CFG_DATA_BITS'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            write_reg(tara_pkg::CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      tara_pkg::CFG_DATA_BITS'($urandom));
        end
    endtask

    // Compare one returned word against the oldest expectation.
    task automatic check_result();
        flip_word_t want;
        if (pending_words.size() == 0) begin
            report_mismatch("word with nothing pending", m_dest_address, '0);
        end else begin
            want = pending_words.pop_front();
            if (m_out_value !== want.value) begin
                report_mismatch("out_value", m_out_value, want.value);
            end
            if (m_dest_address !== want.addr) begin
                report_mismatch("dest_address", m_dest_address, want.addr);
            end
            if (m_last_element !== want.last) begin
                report_mismatch("last_element", {31'd0, m_last_element}, {31'd0, want.last});
            end
        end
    endtask

    // Receiver: checks results and drives m_ready, with an occasional long hold-off.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result();
            end
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when neither channel moves a word for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then random phases with changing idle rates.
    initial begin
        plan_row_t row;
        for (int d = 0; d < NDIM; d++) begin
            shape_size[d] = 16'd1;
            src_pos[d]    = '0;
        end
        flip_mask = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        for (int i = 0; i < PLAN_LEN; i++) begin
            row = PLAN[i];
            if (row.kind == ROW_CFG) begin
                settle_pipeline();
                write_reg(row.idx, row.data);
            end else begin
                push_word(row.value, row.typed, row.addr, row.last);
            end
        end

        // Three idle patterns; the last one opens with a long receiver hold-off.
        for (int m = 0; m < 3; m++) begin
            case (m)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int c = 0; c < CHUNKS; c++) begin
                settle_pipeline();
                pick_shape();
                if (m == 2 && c == 0) begin
                    hold_req <= 1'b1;
                end
                repeat (CHUNK_WORDS) push_word($urandom, 1'b0, '0, 1'b0);
            end
        end

        settle_pipeline();
        repeat (PIPE_DEPTH * 4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/tara_pkg.sv
sv/tara_dim_cell.sv
sv/tensor_axis_reverse_addresser_core.sv
bench/tb_top.sv
